### hdl/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;
  localparam logic [7:0] HEX_ALPHA_BASE = CH_UA - 8'd10;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_truncated;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_NIBBLE,
    OP_JOIN,
    OP_TRUNC
  } op_kind_t;

  // Work handed from the front to the back
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic       last;
  } op_t;

endpackage

### hdl/upd_front.sv
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  upd_pkg::in_word_t word,
  output logic            op_valid,
  output upd_pkg::op_t    op
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  phase_t     phase_r;
  phase_t     phase_nxt;
  logic [7:0] upper;
  logic [7:0] cval;

  // Upper-case, then map hex digits to their value
  always_comb begin
    upper = word.in_byte;
    if (word.in_byte >= upd_pkg::CH_LA && word.in_byte <= upd_pkg::CH_LZ) begin
      upper = word.in_byte - upd_pkg::CASE_GAP;
    end
    if (upper >= upd_pkg::CH_ZERO && upper <= upd_pkg::CH_NINE) begin
      cval = upper - upd_pkg::CH_ZERO;
    end else if (upper >= upd_pkg::CH_UA && upper <= upd_pkg::CH_UF) begin
      cval = upper - upd_pkg::HEX_ALPHA_BASE;
    end else begin
      cval = upper;
    end
  end

  always_comb begin
    phase_nxt  = PH_IDLE;
    op_valid   = 1'b1;
    op.kind    = upd_pkg::OP_EMIT;
    op.value   = word.in_byte;
    op.last    = word.in_last;
    unique case (phase_r)
      PH_FIRST: begin
        if (word.in_last) begin
          op.kind = upd_pkg::OP_TRUNC;
        end else begin
          op.kind   = upd_pkg::OP_NIBBLE;
          op.value  = cval;
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        op.kind  = upd_pkg::OP_JOIN;
        op.value = cval;
      end
      default: begin
        if (word.in_byte == upd_pkg::CH_PERCENT) begin
          if (word.in_last) begin
            op.kind = upd_pkg::OP_TRUNC;
          end else begin
            op_valid  = 1'b0;
            phase_nxt = PH_FIRST;
          end
        end else if (word.in_byte == upd_pkg::CH_PLUS) begin
          op.value = upd_pkg::CH_SPACE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

### hdl/upd_queue.sv
module upd_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  upd_pkg::op_t wr_op,
  output logic         q_full,
  input  logic         rd_en,
  output logic         q_empty,
  output upd_pkg::op_t rd_op
);

  upd_pkg::op_t                  mem_r [upd_pkg::QDEPTH];
  logic [upd_pkg::QAW-1:0]       wptr_r;
  logic [upd_pkg::QAW-1:0]       rptr_r;
  logic [upd_pkg::QCW-1:0]       count_r;

  assign q_full  = (count_r == upd_pkg::QCW'(upd_pkg::QDEPTH));
  assign q_empty = (count_r == '0);
  assign rd_op   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == upd_pkg::QAW'(upd_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == upd_pkg::QAW'(upd_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hdl/upd_back.sv
module upd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  upd_pkg::op_t       q_op,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_word_t out_data
);

  logic               valid_r;
  upd_pkg::out_word_t data_r;
  logic [3:0]         nib_r;
  logic               slot_free;
  logic               emits;
  upd_pkg::out_word_t data_nxt;

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !valid_r || pop;
  assign emits     = (q_op.kind != upd_pkg::OP_NIBBLE);
  assign q_rd      = !q_empty && (!emits || slot_free);
  assign empty     = !valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt.out_byte      = q_op.value;
    data_nxt.out_last      = q_op.last;
    data_nxt.out_truncated = 1'b0;
    unique case (q_op.kind)
      upd_pkg::OP_JOIN: begin
        data_nxt.out_byte = {nib_r, 4'h0} + q_op.value;
      end
      upd_pkg::OP_TRUNC: begin
        data_nxt.out_byte      = '0;
        data_nxt.out_last      = 1'b1;
        data_nxt.out_truncated = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_rd && emits) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      nib_r   <= '0;
    end else begin
      if (q_rd && emits) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
      if (q_rd && q_op.kind == upd_pkg::OP_NIBBLE) begin
        nib_r <= q_op.value[3:0];
      end else if (q_rd && q_op.kind == upd_pkg::OP_TRUNC) begin
        nib_r <= '0;
      end
    end
  end

endmodule

### hdl/url_percent_decoder.sv
// Channel  | Ports                    | Word
// ---------+--------------------------+---------------------------------------
// input    | push, full, in_data      | in_byte, in_last
// result   | pop, empty, out_data     | out_byte, out_last, out_truncated
//
// One word is taken per cycle while full is low. A result passes two registers
// after its word is taken: the front writes the queue at the accepting edge
// and the back then loads the output register from the queue.
// Reset (rst_n low, synchronous) leaves the decoder outside any escape with
// queue and output empty. A stalled result side fills the queue; full then
// rises and holds input until pop drains a word.
module url_percent_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  upd_pkg::in_word_t  in_data,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_word_t out_data
);

  logic         take;
  logic         op_valid;
  upd_pkg::op_t op;
  logic         q_full;
  logic         q_empty;
  logic         q_rd;
  upd_pkg::op_t q_op;

  // Hold input whenever the queue has no room
  assign full = q_full;
  assign take = push && !q_full;

  // Front: track escape phase, classify each character
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .word     (in_data),
    .op_valid (op_valid),
    .op       (op)
  );

  // Queue: a '%' opening an escape writes nothing
  upd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (take && op_valid),
    .wr_op   (op),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .q_empty (q_empty),
    .rd_op   (q_op)
  );

  // Back: hold the first nibble, assemble bytes, drive the result register
  upd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_op     (q_op),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

### verif/tb_url_percent_decoder.sv
module tb_url_percent_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Stop after this many cycles in which neither side moves a word. The limit
  // leaves a wide margin over the longest sender gap and the longest receiver
  // stall.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles to wait once nothing is expected, so that a stray word can show.
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_WORDS   = 1200;

  // Escape progress as the decoder sees it
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPEN,
    PH_HIGH
  } esc_phase_t;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               push     = 1'b0;
  logic               pop      = 1'b0;
  logic               full;
  logic               empty;
  upd_pkg::in_word_t  in_data  = '0;
  upd_pkg::out_word_t out_data;

  // Encoded characters still to be sent, and decoded words still owed
  upd_pkg::in_word_t  pending_chars[$];
  upd_pkg::out_word_t owed_bytes[$];

  // Shadow of the decoder's escape state
  esc_phase_t esc_phase  = PH_IDLE;
  logic [3:0] hi_nibble  = '0;

  int unsigned fail_count   = 0;
  int unsigned chars_sent   = 0;
  int unsigned bytes_seen   = 0;
  int unsigned trunc_seen   = 0;
  int unsigned quiet_cycles = 0;

  url_percent_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Upper-case a letter, then map a hex digit to its value; anything else
  // keeps its (upper-cased) code.
  function automatic logic [7:0] char_value(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (u >= upd_pkg::CH_LA && u <= upd_pkg::CH_LZ) u = u - upd_pkg::CASE_GAP;
    if (u >= upd_pkg::CH_ZERO && u <= upd_pkg::CH_NINE) return u - upd_pkg::CH_ZERO;
    if (u >= upd_pkg::CH_UA && u <= upd_pkg::CH_UF) return u - upd_pkg::HEX_ALPHA_BASE;
    return u;
  endfunction

  // Advance the shadow state by one accepted character; return 1 and the
  // decoded word when the character produces one.
  function automatic bit decode_char(input upd_pkg::in_word_t w,
                                     output upd_pkg::out_word_t r);
    logic [7:0] v;
    r = '0;
    case (esc_phase)
      PH_OPEN: begin
        if (w.in_last) begin
          // String ended right after the '%': flag it and drop the escape
          esc_phase       = PH_IDLE;
          hi_nibble       = '0;
          r.out_last      = 1'b1;
          r.out_truncated = 1'b1;
          return 1'b1;
        end
        v         = char_value(w.in_byte);
        hi_nibble = v[3:0];
        esc_phase = PH_HIGH;
        return 1'b0;
      end
      PH_HIGH: begin
        // Sum wraps at eight bits, so a non-hex second character just adds
        r.out_byte = {hi_nibble, 4'h0} + char_value(w.in_byte);
        r.out_last = w.in_last;
        esc_phase  = PH_IDLE;
        return 1'b1;
      end
      default: begin
        esc_phase = PH_IDLE;
        if (w.in_byte == upd_pkg::CH_PERCENT) begin
          if (w.in_last) begin
            r.out_last      = 1'b1;
            r.out_truncated = 1'b1;
            return 1'b1;
          end
          esc_phase = PH_OPEN;
          return 1'b0;
        end
        r.out_byte = (w.in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : w.in_byte;
        r.out_last = w.in_last;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return upd_pkg::CH_ZERO + n;
    return (lower ? upd_pkg::CH_LA : upd_pkg::CH_UA) + (n - 4'd10);
  endfunction

  task automatic queue_char(input logic [7:0] c, input logic last);
    upd_pkg::in_word_t w;
    w.in_byte = c;
    w.in_last = last;
    pending_chars.push_back(w);
  endtask

  task automatic queue_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++)
      queue_char(s[i], last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] random_hex_char();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic queue_hex_escape(input logic last);
    queue_char(upd_pkg::CH_PERCENT, 1'b0);
    queue_char(random_hex_char(), 1'b0);
    queue_char(random_hex_char(), last);
  endtask

  // One random string: mostly well-formed escapes, '+' and printable text,
  // with some raw bytes and broken escapes mixed in, then a closing character.
  task automatic queue_random_string();
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        queue_hex_escape(1'b0);
      end else if (pick < 40) begin
        queue_char(upd_pkg::CH_PLUS, 1'b0);
      end else if (pick < 52) begin
        queue_char(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 57) begin
        // broken escape: any two characters after the '%'
        queue_char(upd_pkg::CH_PERCENT, 1'b0);
        queue_char(8'($urandom_range(1, 255)), 1'b0);
        queue_char(8'($urandom_range(1, 255)), 1'b0);
      end else begin
        queue_char(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      end
    end
    // Close the string, now and then inside an escape
    case ($urandom_range(0, 9))
      0: queue_char(upd_pkg::CH_PERCENT, 1'b1);
      1: begin
        queue_char(upd_pkg::CH_PERCENT, 1'b0);
        queue_char(random_hex_char(), 1'b1);
      end
      2: queue_hex_escape(1'b1);
      3: queue_char(upd_pkg::CH_PLUS, 1'b1);
      default: queue_char(8'($urandom_range(1, 255)), 1'b1);
    endcase
  endtask

  // Sender: present the oldest pending character in bursts of random length
  // with random gaps, some of them zero so that back-to-back runs occur.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    upd_pkg::out_word_t r;
    if (!rst_n) begin
      push    <= 1'b0;
      in_data <= '0;
    end else begin
      if (push && !full) begin
        // The word on in_data has gone in: predict what it yields
        if (decode_char(in_data, r)) owed_bytes.push_back(r);
        void'(pending_chars.pop_front());
        chars_sent++;
        burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 3);
            default:    gap_left = $urandom_range(4, 30);
          endcase
          burst_left = $urandom_range(1, 40);
        end
      end
      // Hold off during a gap, else offer the next character (or the same
      // one again while full holds it back)
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        push    <= 1'b1;
        in_data <= pending_chars[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each word taken, then choose pop from one of four stall
  // patterns, taken in turn as rx_cycle advances.
  int unsigned rx_cycle = 0;

  always @(posedge clk) begin
    upd_pkg::out_word_t e;
    bit                 moved;
    if (!rst_n) begin
      pop          <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      moved = (push && !full);
      if (pop && !empty) begin
        moved = 1'b1;
        bytes_seen++;
        if (out_data.out_truncated) trunc_seen++;
        if (owed_bytes.size() == 0) begin
          $error("unexpected word: out_byte %02h out_last %0b out_truncated %0b",
                 out_data.out_byte, out_data.out_last, out_data.out_truncated);
          fail_count++;
        end else begin
          e = owed_bytes.pop_front();
          if (out_data.out_byte !== e.out_byte) begin
            $error("out_byte: expected %02h, got %02h", e.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.out_last !== e.out_last) begin
            $error("out_last: expected %0b, got %0b", e.out_last, out_data.out_last);
            fail_count++;
          end
          if (out_data.out_truncated !== e.out_truncated) begin
            $error("out_truncated: expected %0b, got %0b",
                   e.out_truncated, out_data.out_truncated);
            fail_count++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      rx_cycle++;
      case ((rx_cycle / 300) % 4)
        0:       pop <= 1'b1;                          // drain at full rate
        1:       pop <= 1'($urandom_range(0, 1));      // coin toss
        2:       pop <= (rx_cycle % 17) < 5;           // short window, long stall
        default: pop <= ($urandom_range(0, 7) == 0);   // mostly stalled
      endcase
    end
  end

  initial begin
    // Directed strings: range extremes, a zero byte, '+', escapes in both
    // cases, non-hex escape characters, '%' as an escape character, and both
    // kinds of truncated escape plus an escape closed by the last character.
    queue_char(8'h01, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b1);
    queue_char(upd_pkg::CH_PLUS, 1'b1);
    queue_text("%4A", 1'b0);
    queue_text("%fF", 1'b0);
    queue_text("%g~", 1'b0);
    queue_text("%%%", 1'b1);
    queue_text("%", 1'b1);
    queue_text("%4", 1'b1);
    queue_text("%2f", 1'b1);

    while (pending_chars.size() < RANDOM_WORDS + 22) queue_random_string();

    // Hold reset, then release it at a rising edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every character is in and every word is out, or until the
    // watchdog trips
    @(negedge clk);
    while (!(pending_chars.size() == 0 && !push && owed_bytes.size() == 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("timeout: no word moved for %0d cycles, %0d words still owed",
             WATCHDOG_LIMIT, owed_bytes.size());
      fail_count++;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    $display("Sent %0d encoded characters, took %0d decoded words (%0d cut-short escapes)",
             chars_sent, bytes_seen, trunc_seen);
    $display("Mismatches and other failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("tb_url_percent_decoder passed");
    end else begin
      $display("tb_url_percent_decoder failed");
    end
    $finish;
  end

endmodule
